// ===== rtl/qrpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the quaternion rigid point transform.
// No dependencies; used by every module of the block.
package qrpt_pkg;

    // Default field widths: Q16.16 coordinates, Q1.15 quaternion parts
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUAT_WIDTH_DEF  = 16;

    // Entries in the queue between matrix build and point transform
    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/qrpt_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts requests and builds the 3x3 rotation matrix.
// Two registered stages (quaternion products, matrix entries); uses qrpt_pkg.
module qrpt_front #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qrpt_pkg::QUAT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_z,
    input  logic signed [COORD_WIDTH-1:0] i_shift [3],
    input  logic signed [COORD_WIDTH-1:0] i_point [3],
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [2*QUAT_WIDTH+1:0] o_mat [9],
    output logic signed [COORD_WIDTH-1:0] o_shift [3],
    output logic signed [COORD_WIDTH-1:0] o_point [3]
);
    import qrpt_pkg::*;

    localparam int PQ = 2 * QUAT_WIDTH;
    localparam int MW = 2 * QUAT_WIDTH + 2;
    localparam int FRAC = 2 * (QUAT_WIDTH - 1);
    localparam logic signed [MW-1:0] MAT_ONE =
        {{(MW - FRAC - 1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    logic                   r_v1, r_v2;
    logic                   w_adv1, w_adv2;
    logic signed [PQ-1:0]   r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [COORD_WIDTH-1:0] r_t1 [3];
    logic signed [COORD_WIDTH-1:0] r_p1 [3];
    logic signed [MW-1:0]   n_mat [9];
    logic signed [MW-1:0]   r_mat [9];
    logic signed [COORD_WIDTH-1:0] r_t2 [3];
    logic signed [COORD_WIDTH-1:0] r_p2 [3];

    // Advance a stage when it is empty or its contents move on
    assign w_adv2     = !r_v2 || i_out_ready;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_in_ready = w_adv1;

    // Hold stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_in_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    // Stage 1: all quaternion pair products
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_ww <= PQ'(i_quat_w) * PQ'(i_quat_w);
            r_xx <= PQ'(i_quat_x) * PQ'(i_quat_x);
            r_yy <= PQ'(i_quat_y) * PQ'(i_quat_y);
            r_zz <= PQ'(i_quat_z) * PQ'(i_quat_z);
            r_xy <= PQ'(i_quat_x) * PQ'(i_quat_y);
            r_wz <= PQ'(i_quat_w) * PQ'(i_quat_z);
            r_xz <= PQ'(i_quat_x) * PQ'(i_quat_z);
            r_wy <= PQ'(i_quat_w) * PQ'(i_quat_y);
            r_yz <= PQ'(i_quat_y) * PQ'(i_quat_z);
            r_wx <= PQ'(i_quat_w) * PQ'(i_quat_x);
            r_t1 <= i_shift;
            r_p1 <= i_point;
        end
    end

    // Stage 2: matrix entries, diagonal as 2(w^2 + a^2) - 1
    always_comb begin
        n_mat[0] = ((MW'(r_ww) + MW'(r_xx)) <<< 1) - MAT_ONE;
        n_mat[1] = (MW'(r_xy) - MW'(r_wz)) <<< 1;
        n_mat[2] = (MW'(r_xz) + MW'(r_wy)) <<< 1;
        n_mat[3] = (MW'(r_xy) + MW'(r_wz)) <<< 1;
        n_mat[4] = ((MW'(r_ww) + MW'(r_yy)) <<< 1) - MAT_ONE;
        n_mat[5] = (MW'(r_yz) - MW'(r_wx)) <<< 1;
        n_mat[6] = (MW'(r_xz) - MW'(r_wy)) <<< 1;
        n_mat[7] = (MW'(r_yz) + MW'(r_wx)) <<< 1;
        n_mat[8] = ((MW'(r_ww) + MW'(r_zz)) <<< 1) - MAT_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_mat <= n_mat;
            r_t2  <= r_t1;
            r_p2  <= r_p1;
        end
    end

    assign o_out_valid = r_v2;
    assign o_mat       = r_mat;
    assign o_shift     = r_t2;
    assign o_point     = r_p2;

endmodule

// ===== rtl/qrpt_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the matrix front and the transform back.
// Register-file FIFO with wrap-bit pointers; uses qrpt_pkg for its depth.
module qrpt_queue #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = qrpt_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_data
);
    import qrpt_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = IW + 1;

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [AW-1:0]     w_level;
    logic              w_push, w_pop;

    assign w_level     = r_wptr - r_rptr;
    assign o_in_ready  = (w_level != AW'(DEPTH));
    assign o_out_valid = (w_level != '0);
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_data      = r_slot[r_rptr[IW-1:0]];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + AW'(1);
            if (w_pop)  r_rptr <= r_rptr + AW'(1);
        end
    end

    // Store request
    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wptr[IW-1:0]] <= i_data;
    end

    // Fill level never exceeds the depth
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= AW'(DEPTH))
        else $error("queue level beyond depth");

    // Fill level tracks pushes and pops
    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> w_level == $past(w_level) + AW'($past(w_push)) - AW'($past(w_pop)))
        else $error("queue level out of step");

    // Head entry is not disturbed while it waits
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data))
        else $error("queue head changed while stalled");

endmodule

// ===== rtl/qrpt_back.sv =====
`timescale 1ns / 1ps
// Back part: rotates the point by the matrix, adds translation, rounds and saturates.
// Three registered stages (products, row sums, round/saturate); uses qrpt_pkg.
module qrpt_back #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qrpt_pkg::QUAT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [2*QUAT_WIDTH+1:0] i_mat [9],
    input  logic signed [COORD_WIDTH-1:0] i_shift [3],
    input  logic signed [COORD_WIDTH-1:0] i_point [3],
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_world [3]
);
    import qrpt_pkg::*;

    localparam int MW   = 2 * QUAT_WIDTH + 2;
    localparam int FRAC = 2 * (QUAT_WIDTH - 1);
    localparam int PW   = MW + COORD_WIDTH;
    localparam int SW   = PW + 2;
    localparam int RW   = SW - FRAC;
    localparam logic signed [SW-1:0] RND_HALF =
        {{(SW - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    logic                          r_v1, r_v2, r_v3;
    logic                          w_adv1, w_adv2, w_adv3;
    logic signed [PW-1:0]          r_prod [9];
    logic signed [COORD_WIDTH-1:0] r_t1 [3];
    logic signed [SW-1:0]          n_sum [3];
    logic signed [SW-1:0]          r_sum [3];
    logic signed [COORD_WIDTH-1:0] n_world [3];
    logic signed [COORD_WIDTH-1:0] r_world [3];

    assign w_adv3     = !r_v3 || i_out_ready;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_in_ready = w_adv1;

    // Hold stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_in_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    // Stage 1: nine matrix-by-coordinate products
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= PW'(i_mat[k]) * PW'(i_point[k % 3]);
            end
            r_t1 <= i_shift;
        end
    end

    // Stage 2: exact row sums with translation and rounding half added
    // Stage 3: drop fraction bits and clamp to the coordinate range
    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [RW-1:0] w_sh;

        assign n_sum[r] = SW'(r_prod[3*r]) + SW'(r_prod[3*r+1]) + SW'(r_prod[3*r+2])
                        + (SW'(r_t1[r]) <<< FRAC) + RND_HALF;

        assign w_sh = r_sum[r][SW-1:FRAC];

        always_comb begin
            if ((&w_sh[RW-1:COORD_WIDTH-1]) || !(|w_sh[RW-1:COORD_WIDTH-1])) begin
                n_world[r] = w_sh[COORD_WIDTH-1:0];
            end else if (w_sh[RW-1]) begin
                n_world[r] = C_MIN;
            end else begin
                n_world[r] = C_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) r_sum <= n_sum;
        if (w_adv3) r_world <= n_world;
    end

    assign o_out_valid = r_v3;
    assign o_world     = r_world;

    // Stalled sum stage keeps its request
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_adv3 |=> r_v2)
        else $error("sum stage dropped a stalled request");

    // Stalled product stage keeps its request
    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_adv2 |=> r_v1)
        else $error("product stage dropped a stalled request");

    // Full, stalled pipe refuses new requests
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !i_out_ready |-> !o_in_ready)
        else $error("back part took a request while full");

endmodule

// ===== rtl/quaternion_rigid_point_transform.sv =====
`timescale 1ns / 1ps
// Top level of the quaternion rigid point transform.
// Instantiates qrpt_front, qrpt_queue and qrpt_back; uses qrpt_pkg.
//
// Use:
//   Input channel (i_in_valid / o_in_ready) carries one request: a unit
//   quaternion (scalar first, Q1.15), a translation and a body-frame point
//   (Q16.16). Output channel (o_out_valid / i_out_ready) returns the world
//   position R*p + t, rounded to nearest (ties up) and saturated.
//   Throughput: one request per cycle, sustained while i_out_ready stays high,
//   with no gaps between requests. Every stage, the matrix and product
//   stages included, is a pipeline register.
//   Path: a request passes through the two front stages, one queue slot and
//   the three back stages, the last of which is the output register.
//   Stalls: when i_out_ready is low the back stages hold, the four-entry
//   queue absorbs up to four requests from the front, and o_in_ready falls
//   only once the front stages behind a full queue are occupied too.
//   Reset: synchronous, active low; clears all valid bits and queue
//   pointers, so no result is pending afterward. The block keeps no state
//   between requests.
module quaternion_rigid_point_transform #(
    parameter int COORD_WIDTH = qrpt_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = qrpt_pkg::QUAT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_z,
    input  logic signed [COORD_WIDTH-1:0] i_shift_x,
    input  logic signed [COORD_WIDTH-1:0] i_shift_y,
    input  logic signed [COORD_WIDTH-1:0] i_shift_z,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_world_x,
    output logic signed [COORD_WIDTH-1:0] o_world_y,
    output logic signed [COORD_WIDTH-1:0] o_world_z
);
    import qrpt_pkg::*;

    localparam int MW    = 2 * QUAT_WIDTH + 2;
    localparam int C     = COORD_WIDTH;
    localparam int JW    = 9 * MW + 6 * C;
    localparam int T_OFS = 9 * MW;
    localparam int P_OFS = 9 * MW + 3 * C;

    logic signed [C-1:0]  w_shift [3];
    logic signed [C-1:0]  w_point [3];
    logic                 w_f_valid, w_f_ready;
    logic signed [MW-1:0] w_f_mat [9];
    logic signed [C-1:0]  w_f_shift [3];
    logic signed [C-1:0]  w_f_point [3];
    logic [JW-1:0]        w_q_in, w_q_out;
    logic                 w_b_valid, w_b_ready;
    logic signed [MW-1:0] w_b_mat [9];
    logic signed [C-1:0]  w_b_shift [3];
    logic signed [C-1:0]  w_b_point [3];
    logic signed [C-1:0]  w_world [3];

    assign w_shift[0] = i_shift_x;
    assign w_shift[1] = i_shift_y;
    assign w_shift[2] = i_shift_z;
    assign w_point[0] = i_point_x;
    assign w_point[1] = i_point_y;
    assign w_point[2] = i_point_z;

    // Matrix build
    qrpt_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .QUAT_WIDTH  (QUAT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_quat_w    (i_quat_w),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_shift     (w_shift),
        .i_point     (w_point),
        .o_out_valid (w_f_valid),
        .i_out_ready (w_f_ready),
        .o_mat       (w_f_mat),
        .o_shift     (w_f_shift),
        .o_point     (w_f_point)
    );

    // Pack and unpack queue entries
    for (genvar k = 0; k < 9; k++) begin : g_mat
        assign w_q_in[k*MW +: MW] = w_f_mat[k];
        assign w_b_mat[k]         = w_q_out[k*MW +: MW];
    end
    for (genvar k = 0; k < 3; k++) begin : g_vec
        assign w_q_in[T_OFS + k*C +: C] = w_f_shift[k];
        assign w_q_in[P_OFS + k*C +: C] = w_f_point[k];
        assign w_b_shift[k]             = w_q_out[T_OFS + k*C +: C];
        assign w_b_point[k]             = w_q_out[P_OFS + k*C +: C];
    end

    qrpt_queue #(
        .DATA_W (JW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_f_valid),
        .o_in_ready  (w_f_ready),
        .i_data      (w_q_in),
        .o_out_valid (w_b_valid),
        .i_out_ready (w_b_ready),
        .o_data      (w_q_out)
    );

    // Point transform
    qrpt_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .QUAT_WIDTH  (QUAT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_b_valid),
        .o_in_ready  (w_b_ready),
        .i_mat       (w_b_mat),
        .i_shift     (w_b_shift),
        .i_point     (w_b_point),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_world     (w_world)
    );

    assign o_world_x = w_world[0];
    assign o_world_y = w_world[1];
    assign o_world_z = w_world[2];

endmodule

// ===== bench/quaternion_rigid_point_transform_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quaternion_rigid_point_transform: directed and random
// node requests, an in-bench world-position predictor and per-field compare.
// Depends on rtl/qrpt_pkg.sv and rtl/quaternion_rigid_point_transform.sv.
module quaternion_rigid_point_transform_tb;

    localparam int CW        = qrpt_pkg::COORD_WIDTH_DEF;
    localparam int QW        = qrpt_pkg::QUAT_WIDTH_DEF;
    localparam int MAT_FRAC  = 2 * (QW - 1);
    localparam int NUM_PHASE = 4;
    localparam int RAND_PER_PHASE = 108;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (MAT_FRAC - 1);
    localparam logic signed [127:0] COORD_MAX  = (128'sd1 <<< (CW - 1)) - 128'sd1;
    localparam logic signed [127:0] COORD_MIN  = -(128'sd1 <<< (CW - 1));

    // Idle and stall odds per phase, in percent
    localparam int SEND_IDLE  [NUM_PHASE] = '{0, 63, 0, 27};
    localparam int RECV_STALL [NUM_PHASE] = '{0, 0, 63, 27};

    typedef struct {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [CW-1:0] shift_x;
        logic signed [CW-1:0] shift_y;
        logic signed [CW-1:0] shift_z;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } node_request_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } world_pos_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic signed [QW-1:0] i_quat_w    = '0;
    logic signed [QW-1:0] i_quat_x    = '0;
    logic signed [QW-1:0] i_quat_y    = '0;
    logic signed [QW-1:0] i_quat_z    = '0;
    logic signed [CW-1:0] i_shift_x   = '0;
    logic signed [CW-1:0] i_shift_y   = '0;
    logic signed [CW-1:0] i_shift_z   = '0;
    logic signed [CW-1:0] i_point_x   = '0;
    logic signed [CW-1:0] i_point_y   = '0;
    logic signed [CW-1:0] i_point_z   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [CW-1:0] o_world_x;
    logic signed [CW-1:0] o_world_y;
    logic signed [CW-1:0] o_world_z;

    node_request_t nodes_to_send[$];
    world_pos_t    expected_world[$];
    node_request_t node_on_bus;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;

    quaternion_rigid_point_transform uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_quat_w    (i_quat_w),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_shift_x   (i_shift_x),
        .i_shift_y   (i_shift_y),
        .i_shift_z   (i_shift_z),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_world_z   (o_world_z)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // One output coordinate: exact row dot product plus shift, then round half up
    // and clamp to the coordinate width.
    function automatic logic signed [CW-1:0] rotate_row(
        input longint r0, input longint r1, input longint r2,
        input node_request_t n, input logic signed [CW-1:0] shift
    );
        logic signed [127:0] acc;
        logic signed [127:0] a0, a1, a2, px, py, pz, t;
        a0 = 128'(r0);
        a1 = 128'(r1);
        a2 = 128'(r2);
        px = 128'(n.point_x);
        py = 128'(n.point_y);
        pz = 128'(n.point_z);
        t  = 128'(shift);
        acc = a0 * px + a1 * py + a2 * pz + (t <<< MAT_FRAC) + ROUND_HALF;
        acc = acc >>> MAT_FRAC;
        if (acc > COORD_MAX) return COORD_MAX[CW-1:0];
        if (acc < COORD_MIN) return COORD_MIN[CW-1:0];
        return acc[CW-1:0];
    endfunction

    // Build the rotation matrix from the raw quaternion (no normalization) and
    // map the node into the world frame.
    function automatic world_pos_t transform_node(input node_request_t n);
        longint w, x, y, z, one;
        world_pos_t res;
        w   = longint'(n.quat_w);
        x   = longint'(n.quat_x);
        y   = longint'(n.quat_y);
        z   = longint'(n.quat_z);
        one = longint'(1) << MAT_FRAC;
        res.x = rotate_row(2 * (w * w + x * x) - one, 2 * (x * y - w * z),
                           2 * (x * z + w * y), n, n.shift_x);
        res.y = rotate_row(2 * (x * y + w * z), 2 * (w * w + y * y) - one,
                           2 * (y * z - w * x), n, n.shift_y);
        res.z = rotate_row(2 * (x * z - w * y), 2 * (y * z + w * x),
                           2 * (w * w + z * z) - one, n, n.shift_z);
        return res;
    endfunction

    function automatic node_request_t make_node(
        input int qw, input int qx, input int qy, input int qz,
        input int sx, input int sy, input int sz,
        input int px, input int py, input int pz
    );
        node_request_t n;
        n.quat_w  = qw[QW-1:0];
        n.quat_x  = qx[QW-1:0];
        n.quat_y  = qy[QW-1:0];
        n.quat_z  = qz[QW-1:0];
        n.shift_x = sx;
        n.shift_y = sy;
        n.shift_z = sz;
        n.point_x = px;
        n.point_y = py;
        n.point_z = pz;
        return n;
    endfunction

    // Append one request to the driver's pending list
    function automatic void add_node(input node_request_t n);
        nodes_to_send = {nodes_to_send, n};
    endfunction

    // Coordinate with a random magnitude scale so small and large values both show up
    function automatic logic signed [CW-1:0] random_coord(input bit full_range);
        logic signed [CW-1:0] v;
        v = $urandom;
        if (full_range) return v;
        return v >>> $urandom_range(CW - 1, 1);
    endfunction

    // Mostly near-unit rotations with moderate coordinates; the rest raw noise
    function automatic node_request_t random_node();
        node_request_t n;
        real a, b, c, d, norm;
        bit noise;
        noise = ($urandom_range(99) < 25);
        if (noise) begin
            n.quat_w = QW'($urandom);
            n.quat_x = QW'($urandom);
            n.quat_y = QW'($urandom);
            n.quat_z = QW'($urandom);
        end else begin
            a = real'($urandom_range(2000)) / 1000.0 - 1.0;
            b = real'($urandom_range(2000)) / 1000.0 - 1.0;
            c = real'($urandom_range(2000)) / 1000.0 - 1.0;
            d = real'($urandom_range(2000)) / 1000.0 - 1.0;
            norm = $sqrt(a * a + b * b + c * c + d * d);
            if (norm < 0.001) begin
                a = 1.0;
                norm = 1.0;
            end
            n.quat_w = QW'($rtoi(a / norm * 32767.0));
            n.quat_x = QW'($rtoi(b / norm * 32767.0));
            n.quat_y = QW'($rtoi(c / norm * 32767.0));
            n.quat_z = QW'($rtoi(d / norm * 32767.0));
        end
        n.shift_x = random_coord(noise);
        n.shift_y = random_coord(noise);
        n.shift_z = random_coord(noise);
        n.point_x = random_coord(noise);
        n.point_y = random_coord(noise);
        n.point_z = random_coord(noise);
        return n;
    endfunction

    // Driver: predict on acceptance, then load the next request or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_world = {expected_world, transform_node(node_on_bus)};
            end
            if (!i_in_valid || o_in_ready) begin
                if (nodes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    node_on_bus = nodes_to_send.pop_front();
                    i_quat_w   <= node_on_bus.quat_w;
                    i_quat_x   <= node_on_bus.quat_x;
                    i_quat_y   <= node_on_bus.quat_y;
                    i_quat_z   <= node_on_bus.quat_z;
                    i_shift_x  <= node_on_bus.shift_x;
                    i_shift_y  <= node_on_bus.shift_y;
                    i_shift_z  <= node_on_bus.shift_z;
                    i_point_x  <= node_on_bus.point_x;
                    i_point_y  <= node_on_bus.point_y;
                    i_point_z  <= node_on_bus.point_z;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        world_pos_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_world.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: unexpected result x=%0d y=%0d z=%0d",
                                 o_world_x, o_world_y, o_world_z);
                end else begin
                    want = expected_world.pop_front();
                    if (o_world_x !== want.x || o_world_y !== want.y
                            || o_world_z !== want.z) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("ERROR: world mismatch exp (%0d %0d %0d) got (%0d %0d %0d)",
                                     want.x, want.y, want.z,
                                     o_world_x, o_world_y, o_world_z);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: stop if work is outstanding and nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (nodes_to_send.size() > 0 || expected_world.size() > 0
                         || i_in_valid) begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int ph;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < NUM_PHASE; ph++) begin
            @(negedge i_clk);
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            if (ph == 0) begin
                // exact identity (w = -1.0) and the near-identity w = max
                add_node(make_node(-32768, 0, 0, 0, 0, 0, 0,
                                   98304, -147456, 196608));
                add_node(make_node(32767, 0, 0, 0, 65536, -65536, 7,
                                   98304, -147456, 196608));
                // zero quaternion gives -1 on the diagonal
                add_node(make_node(0, 0, 0, 0, 100, 200, 300,
                                   1000, -2000, 3000));
                // diagonal -0.5: rounding ties go toward plus infinity
                add_node(make_node(16384, 0, 0, 0, 0, 0, 0, 1, -1, 3));
                add_node(make_node(16384, 0, 0, 0, 0, 0, 0, -3, 5, -5));
                // quarter turn about z, then half turns about x, y and z
                add_node(make_node(23170, 0, 0, 23170, 0, 0, 0,
                                   65536, 131072, -65536));
                add_node(make_node(0, -32768, 0, 0, 12345, -54321, 0,
                                   65536, 131072, -65536));
                add_node(make_node(0, 0, 32767, 0, 0, 0, 0,
                                   -65536, 65536, 65536));
                add_node(make_node(0, 0, 0, -32768, -1, -1, -1,
                                   1, 1, 1));
                // non-unit quaternions scale and push into saturation
                add_node(make_node(-32768, -32768, -32768, -32768,
                                   0, 0, 0, 2147483647, 2147483647,
                                   2147483647));
                add_node(make_node(32767, 32767, 32767, 32767,
                                   2147483647, 2147483647, 2147483647,
                                   2147483647, 2147483647, 2147483647));
                add_node(make_node(-32768, -32768, -32768, -32768,
                                   -2147483648, -2147483648, -2147483648,
                                   -2147483648, -2147483648, -2147483648));
                // identity with shift and point both at one extreme
                add_node(make_node(-32768, 0, 0, 0,
                                   2147483647, -2147483648, 2147483647,
                                   2147483647, -2147483648, 1));
                add_node(make_node(-32768, 0, 0, 0,
                                   -2147483648, 2147483647, -2147483648,
                                   -2147483648, 2147483647, -1));
                // mixed signs, half turn with large point near the rails
                add_node(make_node(32767, -32768, 32767, -32768,
                                   -2147483648, 2147483647, 0,
                                   2147483647, -2147483648, 0));
                add_node(make_node(0, 32767, 0, 0, 0, 0, 0,
                                   -2147483648, -2147483648, -2147483648));
                add_node(make_node(-1, 1, -1, 1, -1, 1, -1, -1, 1, -1));
            end
            for (k = 0; k < RAND_PER_PHASE; k++)
                add_node(random_node());
            // hold until this phase has fully drained
            while (nodes_to_send.size() > 0 || i_in_valid || expected_world.size() > 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_world.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qrpt_pkg.sv
rtl/qrpt_front.sv
rtl/qrpt_queue.sv
rtl/qrpt_back.sv
rtl/quaternion_rigid_point_transform.sv
bench/quaternion_rigid_point_transform_tb.sv
